[src/pn_pkg.sv]
// Shared types and constants for the peak normaliser.
// No dependencies; compile first.
package pn_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 1024;
    localparam int DEFAULT_SAMPLE_WIDTH = 16;
    localparam int GAIN_WIDTH           = 8;
    localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = GAIN_WIDTH'(1);

    typedef enum logic [1:0] {
        RES_EMPTY,
        RES_ZERO,
        RES_SAT,
        RES_QUOT
    } res_kind_t;

    typedef struct packed {
        logic      load;
        logic      read;
        logic      mult;
        logic      div_init;
        logic      div_step;
        logic      emit;
        res_kind_t kind;
    } pn_cmd_t;

    typedef struct packed {
        logic empty;
        logic trivial;
        logic over;
        logic div_last;
        logic out_free;
    } pn_stat_t;

endpackage

[src/pn_if.sv]
// Handshake channels of the peak normaliser: request, result and gain write.
// Depends on pn_pkg.
interface pn_req_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output cmd, output sample_in, input ready);
    modport sink   (input valid, input cmd, input sample_in, output ready);
endinterface

interface pn_res_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           saturated;
    logic                           last_of_block;
    logic                           empty_res;

    modport source (output valid, output sample_out, output saturated,
                    output last_of_block, output empty_res, input ready);
    modport sink   (input valid, input sample_out, input saturated,
                    input last_of_block, input empty_res, output ready);
endinterface

interface pn_cfg_if
    import pn_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [GAIN_WIDTH-1:0] gain;

    modport source (output valid, output gain, input ready);
    modport sink   (input valid, input gain, output ready);
endinterface

[src/pn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/pn_ctrl.sv]
// Sequencer of the peak normaliser: handshake on the request side and
// command issue to the datapath. Depends on pn_pkg.
module pn_ctrl
    import pn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_cmd,
    output logic     in_ready,
    input  pn_stat_t stat,
    output pn_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_DIV,
        S_EMIT
    } state_t;

    state_t    state_reg, state_next;
    res_kind_t kind_reg, kind_next;

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.kind     = kind_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = ~in_cmd;
                    cmd.read = in_cmd;
                    if (in_cmd)
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                cmd.mult = 1'b1;
                if (stat.empty)
                begin
                    kind_next  = RES_EMPTY;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (stat.trivial)
                begin
                    kind_next  = RES_ZERO;
                    state_next = S_EMIT;
                end
                else if (stat.over)
                begin
                    kind_next  = RES_SAT;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    kind_next  = RES_QUOT;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= RES_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result issued while output slot busy");

    a_div_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && stat.div_last) |=> state_reg == S_EMIT)
        else $error("division end not followed by emit");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_cmd) |=> !in_ready)
        else $error("read request did not block further requests");

endmodule

[src/pn_dp.sv]
// Datapath of the peak normaliser: sample buffer, peak tracking, scaling
// multiplier, restoring divider and result register. Depends on pn_pkg, pn_ram.
module pn_dp
    import pn_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH,
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pn_cmd_t                        cmd,
    output pn_stat_t                       stat,
    input  logic                           cfg_valid,
    input  logic [GAIN_WIDTH-1:0]          cfg_gain,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           saturated,
    output logic                           last_of_block,
    output logic                           empty_res
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int PW = SW + GAIN_WIDTH;
    localparam int DW = $clog2(SW);
    localparam logic [SW-1:0] POS_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] NEG_MAX = {1'b1, {(SW-1){1'b0}}};

    logic [GAIN_WIDTH-1:0] gain_reg;
    logic [SW-1:0]         peak_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         pos_reg;
    logic                  phase_reg;
    logic                  empty_reg;
    logic                  last_reg;
    logic                  neg_reg;
    logic [PW-1:0]         prod_reg;
    logic [SW-1:0]         rem_reg;
    logic [SW-1:0]         quo_reg;
    logic [DW-1:0]         cnt_reg;
    logic                  out_valid_reg;
    logic [SW-1:0]         out_sample_reg;
    logic                  out_sat_reg;
    logic                  out_last_reg;
    logic                  out_empty_reg;

    logic [CW-1:0] eff_count;
    logic [SW-1:0] eff_peak;
    logic          space;
    logic [SW-1:0] in_mag;
    logic          we;
    logic [SW-1:0] rdata;
    logic          rd_neg;
    logic [SW-1:0] rd_mag;
    logic          pos_end;
    logic          rem_ge;
    logic [SW-1:0] rem_diff;
    logic [SW-1:0] quo_neg;

    assign eff_count = phase_reg ? '0 : count_reg;
    assign eff_peak  = phase_reg ? '0 : peak_reg;
    assign space     = eff_count < CW'(BUFFER_DEPTH);
    assign in_mag    = sample_in[SW-1] ? (~SW'(sample_in) + SW'(1)) : SW'(sample_in);
    assign we        = cmd.load && space;
    assign pos_end   = pos_reg >= count_reg;

    pn_ram #(
        .WIDTH (SW),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (eff_count[AW-1:0]),
        .wdata (SW'(sample_in)),
        .re    (cmd.read),
        .raddr (pos_reg[AW-1:0]),
        .rdata (rdata)
    );

    assign rd_neg   = rdata[SW-1];
    assign rd_mag   = rd_neg ? (~rdata + SW'(1)) : rdata;
    assign rem_ge   = rem_reg >= peak_reg;
    assign rem_diff = rem_ge ? (rem_reg - peak_reg) : rem_reg;
    assign quo_neg  = ~quo_reg + SW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RESET;
            peak_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                gain_reg <= cfg_gain;
            end
            if (cmd.load)
            begin
                phase_reg <= 1'b0;
                if (phase_reg)
                begin
                    pos_reg <= '0;
                end
                count_reg <= space ? eff_count + CW'(1) : eff_count;
                peak_reg  <= (space && in_mag > eff_peak) ? in_mag : eff_peak;
            end
            if (cmd.read)
            begin
                phase_reg <= 1'b1;
                if (!pos_end)
                begin
                    pos_reg <= pos_reg + CW'(1);
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            empty_reg <= pos_end;
            last_reg  <= ({1'b0, pos_reg} + (CW+1)'(1)) == {1'b0, count_reg};
        end
        if (cmd.mult)
        begin
            neg_reg  <= rd_neg;
            prod_reg <= PW'(rd_mag) * PW'(gain_reg);
        end
        if (cmd.div_init)
        begin
            rem_reg <= prod_reg[SW-1:0];
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= {rem_diff[SW-2:0], 1'b0};
            quo_reg <= {quo_reg[SW-2:0], rem_ge};
            cnt_reg <= cnt_reg + DW'(1);
        end
        if (cmd.emit)
        begin
            out_last_reg  <= (cmd.kind == RES_EMPTY) ? 1'b0 : last_reg;
            out_empty_reg <= cmd.kind == RES_EMPTY;
            unique case (cmd.kind)
                RES_EMPTY, RES_ZERO:
                begin
                    out_sample_reg <= '0;
                    out_sat_reg    <= 1'b0;
                end
                RES_SAT:
                begin
                    out_sample_reg <= neg_reg ? NEG_MAX : POS_MAX;
                    out_sat_reg    <= 1'b1;
                end
                RES_QUOT:
                begin
                    if (neg_reg)
                    begin
                        out_sample_reg <= quo_neg;
                        out_sat_reg    <= 1'b0;
                    end
                    else
                    begin
                        out_sample_reg <= quo_reg[SW-1] ? POS_MAX : quo_reg;
                        out_sat_reg    <= quo_reg[SW-1];
                    end
                end
                default:
                begin
                    out_sample_reg <= '0;
                    out_sat_reg    <= 1'b0;
                end
            endcase
        end
    end

    assign stat.empty    = empty_reg;
    assign stat.trivial  = (peak_reg == '0) || (prod_reg == '0);
    assign stat.over     = prod_reg > PW'(peak_reg);
    assign stat.div_last = cnt_reg == DW'(SW - 1);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign sample_out    = out_sample_reg;
    assign saturated     = out_sat_reg;
    assign last_of_block = out_last_reg;
    assign empty_res     = out_empty_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(BUFFER_DEPTH))
        else $error("loaded count beyond buffer depth");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= count_reg)
        else $error("read position beyond loaded count");

    a_div_peak: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (peak_reg != '0 && rem_reg < {peak_reg[SW-2:0], 1'b0}
                          || peak_reg != '0 && peak_reg[SW-1]))
        else $error("divider remainder out of range");

endmodule

[src/peak_normaliser.sv]
// Peak normaliser top level: request, result and gain channels around the
// controller (pn_ctrl) and datapath (pn_dp). Depends on pn_pkg and pn_if.
//
// Load requests (cmd 0) store a sample, unless the buffer is full, and update
// the block peak. Read requests (cmd 1) return the next stored sample scaled
// by gain / peak, saturated: one buffer read, one multiply, one range check,
// SAMPLE_WIDTH steps of the bit-serial restoring divider and one output load;
// zero, saturated and empty results skip the divider. The user must write the
// gain register only while idle; the block itself does not enforce it.
module peak_normaliser
    import pn_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH,
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
    input  logic     clk,
    input  logic     rst_n,
    pn_cfg_if.sink   cfg,
    pn_req_if.sink   req,
    pn_res_if.source res
);

    pn_cmd_t  cmd;
    pn_stat_t stat;

    assign cfg.ready = 1'b1;

    pn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_cmd   (req.cmd),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pn_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg.valid),
        .cfg_gain      (cfg.gain),
        .sample_in     (req.sample_in),
        .out_valid     (res.valid),
        .out_ready     (res.ready),
        .sample_out    (res.sample_out),
        .saturated     (res.saturated),
        .last_of_block (res.last_of_block),
        .empty_res     (res.empty_res)
    );

endmodule

[tb/tb_peak_normaliser.sv]
`timescale 1ns / 100ps
// Self-checking bench for peak_normaliser: a queued request driver, a result monitor and
// a block predictor that scales by gain / peak. Depends on pn_pkg, pn_if and the top level.
module tb_peak_normaliser;
    import pn_pkg::*;

    localparam int DEPTH        = DEFAULT_BUFFER_DEPTH;
    localparam int SW           = DEFAULT_SAMPLE_WIDTH;
    localparam int DRAIN_CYCLES = 2 * (SW + 4);
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_READ   = 1'b1;
    localparam logic signed [SW-1:0] FS_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] FS_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct packed {
        logic                 cmd;
        logic signed [SW-1:0] sample;
    } request_t;

    typedef struct packed {
        logic signed [SW-1:0] value;
        logic                 sat;
        logic                 last;
        logic                 empty;
    } scaled_t;

    logic clk = 1'b0;
    logic rst_n;

    pn_cfg_if                        cfg_ch();
    pn_req_if #(.SAMPLE_WIDTH(SW))   req_ch();
    pn_res_if #(.SAMPLE_WIDTH(SW))   res_ch();

    peak_normaliser #(
        .BUFFER_DEPTH(DEPTH),
        .SAMPLE_WIDTH(SW)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg_ch),
        .req  (req_ch),
        .res  (res_ch)
    );

    always #2 clk = ~clk;

    request_t pending[$];
    scaled_t  scaled_due[$];

    // predicted block state
    logic signed [SW-1:0]  blk_store [DEPTH];
    longint                blk_peak    = 0;
    int                    blk_count   = 0;
    int                    blk_rpos    = 0;
    bit                    blk_reading = 1'b0;
    logic [GAIN_WIDTH-1:0] gain_now    = GAIN_RESET;

    bit drv_eager    = 1'b0;
    bit mon_eager    = 1'b0;
    int gap_cycles   = 0;
    int stall_cycles = 0;
    int errors       = 0;
    int n_loads      = 0;
    int n_reads      = 0;
    int n_gain_wr    = 0;
    int n_checked    = 0;
    int n_sat        = 0;
    int n_last       = 0;
    int n_empty      = 0;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("ERROR %0t ns: %s", $time, msg);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic signed [SW-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return FS_MIN;
            1: return FS_MAX;
            2: return SW'(int'($urandom_range(0, 16)) - 8);
            3: return SW'(int'($urandom_range(0, 4000)) - 2000);
            default: return SW'($urandom());
        endcase
    endfunction

    // update block state for one accepted request, queue the scaled result of a read
    task automatic normalise_request(input request_t rq);
        scaled_t r;
        longint  s;
        longint  mag;
        longint  prod;
        longint  q;
        r = '0;
        if (rq.cmd == CMD_LOAD) begin
            n_loads++;
            if (blk_reading) begin
                blk_reading = 1'b0;
                blk_peak    = 0;
                blk_count   = 0;
                blk_rpos    = 0;
            end
            if (blk_count < DEPTH) begin
                s   = rq.sample;
                mag = (s < 0) ? -s : s;
                blk_store[blk_count] = rq.sample;
                blk_count++;
                if (mag > blk_peak)
                    blk_peak = mag;
            end
        end
        else begin
            n_reads++;
            blk_reading = 1'b1;
            if (blk_rpos >= blk_count) begin
                r.empty = 1'b1;
            end
            else begin
                s    = blk_store[blk_rpos];
                mag  = (s < 0) ? -s : s;
                prod = mag * longint'(gain_now);
                if (blk_peak == 0 || prod == 0) begin
                    r.value = '0;
                end
                else if (prod > blk_peak) begin
                    r.sat   = 1'b1;
                    r.value = (s < 0) ? FS_MIN : FS_MAX;
                end
                else begin
                    q = (prod << (SW - 1)) / blk_peak;
                    if (s < 0) begin
                        r.value = SW'(-q);
                    end
                    else if (q > longint'(FS_MAX)) begin
                        r.sat   = 1'b1;
                        r.value = FS_MAX;
                    end
                    else begin
                        r.value = SW'(q);
                    end
                end
                r.last = (blk_rpos + 1 == blk_count);
                blk_rpos++;
            end
            scaled_due.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        bit took;
        if (!rst_n) begin
            req_ch.valid     <= 1'b0;
            req_ch.cmd       <= CMD_LOAD;
            req_ch.sample_in <= '0;
            gap_cycles = 0;
        end
        else begin
            took = req_ch.valid && req_ch.ready;
            if (took)
                normalise_request(pending.pop_front());
            if (!req_ch.valid || took) begin
                if (gap_cycles > 0) begin
                    gap_cycles--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending.size() > 0) begin
                    req_ch.valid     <= 1'b1;
                    req_ch.cmd       <= pending[0].cmd;
                    req_ch.sample_in <= pending[0].sample;
                    gap_cycles = drv_eager ? 0 : pick_gap();
                end
                else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        scaled_t want;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            stall_cycles = 0;
        end
        else begin
            if (res_ch.valid && res_ch.ready) begin
                if (scaled_due.size() == 0) begin
                    report_mismatch($sformatf("result with none expected: sample_out %0d",
                                              res_ch.sample_out));
                end
                else begin
                    want = scaled_due.pop_front();
                    n_checked++;
                    n_sat   += want.sat;
                    n_last  += want.last;
                    n_empty += want.empty;
                    if (res_ch.sample_out !== want.value)
                        report_mismatch($sformatf("result %0d: sample_out %0d, expected %0d",
                                                  n_checked, res_ch.sample_out, want.value));
                    if (res_ch.saturated !== want.sat)
                        report_mismatch($sformatf("result %0d: saturated %b, expected %b",
                                                  n_checked, res_ch.saturated, want.sat));
                    if (res_ch.last_of_block !== want.last)
                        report_mismatch($sformatf("result %0d: last_of_block %b, expected %b",
                                                  n_checked, res_ch.last_of_block, want.last));
                    if (res_ch.empty_res !== want.empty)
                        report_mismatch($sformatf("result %0d: empty_res %b, expected %b",
                                                  n_checked, res_ch.empty_res, want.empty));
                end
            end
            if (stall_cycles > 0) begin
                stall_cycles--;
                res_ch.ready <= 1'b0;
            end
            else begin
                res_ch.ready <= 1'b1;
                if (!mon_eager && $urandom_range(0, 3) == 0)
                    stall_cycles = pick_gap();
            end
        end
    end

    task automatic queue_request(input logic cmd, input logic signed [SW-1:0] sample);
        request_t rq;
        rq.cmd    = cmd;
        rq.sample = sample;
        pending.push_back(rq);
    endtask

    task automatic queue_reads(input int count);
        repeat (count) queue_request(CMD_READ, random_sample());
    endtask

    // wait until every request is taken and every result is in, then let the block settle
    task automatic drain();
        while (pending.size() != 0 || scaled_due.size() != 0 || req_ch.valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gain(input logic [GAIN_WIDTH-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.gain  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        gain_now = value;
        n_gain_wr++;
        cfg_ch.valid <= 1'b0;
    endtask

    // mostly whole blocks: loads then a full, short or overlong readout; some noise
    task automatic queue_random_phase(input int target);
        int queued;
        int pick;
        int n;
        int m;
        queued = 0;
        while (queued < target) begin
            pick = $urandom_range(0, 9);
            if (pick == 9) begin
                n = $urandom_range(1, 4);
                repeat (n) queue_request(1'($urandom_range(0, 1)), random_sample());
                queued += n;
            end
            else begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                                : $urandom_range(1, 12);
                repeat (n) queue_request(CMD_LOAD, random_sample());
                if (pick < 6)
                    m = n;
                else if (pick < 8)
                    m = n + $urandom_range(1, 2);
                else
                    m = $urandom_range(0, n - 1);
                queue_reads(m);
                queued += n + m;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [GAIN_WIDTH-1:0] phase_gain [8];
        phase_gain = '{8'd255, 8'd2, 8'd0, 8'd1, 8'd3, 8'(0), 8'(0), 8'd128};
        phase_gain[5] = GAIN_WIDTH'($urandom_range(0, 255));
        phase_gain[6] = GAIN_WIDTH'($urandom_range(1, 7));
        req_ch.valid     = 1'b0;
        req_ch.cmd       = CMD_LOAD;
        req_ch.sample_in = '0;
        res_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.gain      = GAIN_RESET;
        rst_n            = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset gain: read with nothing loaded, full-scale extremes, zero and unit samples
        queue_reads(1);
        queue_request(CMD_LOAD, FS_MAX);
        queue_request(CMD_LOAD, FS_MIN);
        queue_request(CMD_LOAD, SW'(0));
        queue_request(CMD_LOAD, SW'(1));
        queue_request(CMD_LOAD, -SW'(1));
        queue_reads(6);
        drain();

        // positive sample equal to peak clips; all-zero block gives zero peak
        write_gain(GAIN_WIDTH'(1));
        queue_request(CMD_LOAD, SW'(12345));
        queue_request(CMD_LOAD, -SW'(12345));
        queue_request(CMD_LOAD, SW'(6000));
        queue_reads(3);
        queue_request(CMD_LOAD, SW'(0));
        queue_request(CMD_LOAD, SW'(0));
        queue_reads(2);
        drain();

        write_gain(GAIN_WIDTH'(0));
        queue_request(CMD_LOAD, SW'(1000));
        queue_request(CMD_LOAD, -SW'(3));
        queue_reads(2);
        drain();

        // full buffer; extra large loads must be dropped without touching the peak
        write_gain(GAIN_WIDTH'(1));
        repeat (DEPTH) queue_request(CMD_LOAD, SW'(int'($urandom_range(0, 32000)) - 16000));
        repeat (6) queue_request(CMD_LOAD, FS_MIN);
        queue_reads(DEPTH + 1);
        drain();

        for (int p = 0; p < 8; p++) begin
            drv_eager = (p == 2 || p == 6);
            mon_eager = (p == 4 || p == 6);
            write_gain(phase_gain[p]);
            queue_random_phase(63);
            drain();
        end
        drv_eager = 1'b0;
        mon_eager = 1'b0;

        $display("Run: %0d loads, %0d reads, %0d gain writes (0, 1 and 255 among them)",
                 n_loads, n_reads, n_gain_wr);
        $display("     %0d results checked: %0d clipped, %0d end of block, %0d empty",
                 n_checked, n_sat, n_last, n_empty);
        if (errors == 0 && scaled_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Timeout: %0d requests queued, %0d results outstanding",
                 pending.size(), scaled_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
